// File: hw/rtl/ffrx_pkg.sv
package ffrx_pkg;

  localparam int POS_W      = 5;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 32;
  localparam int OUT_DATA_W = BYTE_W + 4 * WORD_W;

  localparam logic [POS_W-1:0] CHECK_POS     = POS_W'(18);
  localparam logic [POS_W-1:0] TAIL_POS      = POS_W'(19);
  localparam int               LAST_DATA_POS = 17;
  localparam int               CMD_POS       = 1;
  localparam int               WORD_X_POS    = 2;
  localparam int               WORD_Y_POS    = 6;
  localparam int               WORD_Z_POS    = 10;
  localparam int               WORD_U_POS    = 14;

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h7A;
  localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'h7B;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REJECT   = 2'd1,
    ST_BAD_TAIL = 2'd2
  } status_t;

  typedef enum logic {
    REG_HEADER = 1'b0,
    REG_TAIL   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] header_byte;
    logic [BYTE_W-1:0] tail_byte;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] word_u;
    logic [WORD_W-1:0] word_z;
    logic [WORD_W-1:0] word_y;
    logic [WORD_W-1:0] word_x;
    logic [BYTE_W-1:0] command;
  } frame_data_t;

  typedef struct packed {
    logic        last_slot;
    logic        done;
    status_t     status;
    frame_data_t data;
  } frame_res_t;

endpackage

// File: hw/rtl/ffrx_regs.sv
module ffrx_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ffrx_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ffrx_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ffrx_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output ffrx_pkg::cfg_t                   cfg
);
  import ffrx_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  // registers sit on word addresses, low address bits are ignored
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte <= HEADER_RESET;
      cfg.tail_byte   <= TAIL_RESET;
    end else if (wr_en && pready) begin
      case (idx)
        REG_HEADER: cfg.header_byte <= pwdata[BYTE_W-1:0];
        REG_TAIL:   cfg.tail_byte   <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HEADER: prdata = APB_DATA_W'(cfg.header_byte);
      REG_TAIL:   prdata = APB_DATA_W'(cfg.tail_byte);
      default:    prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/ffrx_frame.sv
module ffrx_frame (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [ffrx_pkg::BYTE_W-1:0]   rx_byte,
  input  logic                          stop_active,
  input  ffrx_pkg::cfg_t                cfg,
  output ffrx_pkg::frame_res_t          res
);
  import ffrx_pkg::*;

  logic [POS_W-1:0]  pos;
  logic [BYTE_W-1:0] xor_acc;
  logic              check_ok;
  logic [BYTE_W-1:0] frame_bytes [1:LAST_DATA_POS];
  logic              is_last;

  function automatic logic [WORD_W-1:0] le_word(input logic [BYTE_W-1:0] b0,
                                                 input logic [BYTE_W-1:0] b1,
                                                 input logic [BYTE_W-1:0] b2,
                                                 input logic [BYTE_W-1:0] b3);
    return {b3, b2, b1, b0};
  endfunction

  assign is_last = (pos == TAIL_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      if (is_last) begin
        pos <= '0;
      end else if (pos != '0 || rx_byte == cfg.header_byte) begin
        pos <= pos + POS_W'(1);
      end else begin
        pos <= '0;
      end
    end
  end

  // running xor over bytes 0..17, compared against byte 18 as it arrives
  always_ff @(posedge clk) begin
    if (accept) begin
      if (pos == '0) begin
        xor_acc <= rx_byte;
      end else if (pos < CHECK_POS) begin
        xor_acc <= xor_acc ^ rx_byte;
      end
      if (pos == CHECK_POS) begin
        check_ok <= (xor_acc == rx_byte);
      end
      for (int i = 1; i <= LAST_DATA_POS; i++) begin
        if (pos == POS_W'(i)) begin
          frame_bytes[i] <= rx_byte;
        end
      end
    end
  end

  always_comb begin
    res.last_slot = is_last;
    res.done      = accept & is_last;
    if (rx_byte != cfg.tail_byte) begin
      res.status = ST_BAD_TAIL;
    end else if (!check_ok || stop_active) begin
      res.status = ST_REJECT;
    end else begin
      res.status = ST_OK;
    end
    res.data.command = frame_bytes[CMD_POS];
    res.data.word_x  = le_word(frame_bytes[WORD_X_POS], frame_bytes[WORD_X_POS+1],
                               frame_bytes[WORD_X_POS+2], frame_bytes[WORD_X_POS+3]);
    res.data.word_y  = le_word(frame_bytes[WORD_Y_POS], frame_bytes[WORD_Y_POS+1],
                               frame_bytes[WORD_Y_POS+2], frame_bytes[WORD_Y_POS+3]);
    res.data.word_z  = le_word(frame_bytes[WORD_Z_POS], frame_bytes[WORD_Z_POS+1],
                               frame_bytes[WORD_Z_POS+2], frame_bytes[WORD_Z_POS+3]);
    res.data.word_u  = le_word(frame_bytes[WORD_U_POS], frame_bytes[WORD_U_POS+1],
                               frame_bytes[WORD_U_POS+2], frame_bytes[WORD_U_POS+3]);
  end

endmodule

// File: hw/rtl/fixed_frame_receiver_xor_check.sv
// Receives a byte stream and cuts it into fixed 20-byte frames that open on the
// header byte. Byte 19 must match the tail byte, byte 18 the XOR of bytes 0 to 17,
// and the stop flag sent with the last byte must be clear. Each completed frame
// yields one transfer with a status (0 ok, 1 checksum fail or stopped, 2 bad tail),
// the command byte and four little-endian 32-bit words from bytes 2-17; bytes that
// do not complete a frame yield nothing. One byte is taken every clock cycle; the
// result is registered and appears on the cycle after the 20th byte. Only while a
// finished result is still held and the next byte would close another frame does
// s_tready drop. Header and tail bytes are set over the APB port (addresses 0, 4).
module fixed_frame_receiver_xor_check (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // rx_byte
  input  logic                              s_tuser,   // stop_active
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // command, word_x, word_y, word_z, word_u
  output logic [ffrx_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic [1:0]                        m_tuser,   // status
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ffrx_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [ffrx_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [ffrx_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import ffrx_pkg::*;

  cfg_t        cfg;
  frame_res_t  res;
  logic        accept;

  ffrx_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ffrx_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (s_tdata),
    .stop_active (s_tuser),
    .cfg         (cfg),
    .res         (res)
  );

  // only a frame-closing byte needs a free output register
  assign s_tready = !res.last_slot || !m_tvalid || m_tready;
  assign accept   = s_tvalid & s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      m_tdata <= res.data;
      m_tuser <= res.status;
    end
  end

endmodule

// File: hw/rtl/ffrx_checker.sv
module ffrx_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [ffrx_pkg::OUT_DATA_W-1:0]  m_tdata,
  input logic [1:0]                       m_tuser
);
  import ffrx_pkg::*;

  // held result must not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_REJECT || m_tuser == ST_BAD_TAIL))
    else $error("status out of range");

  // a new result only follows an input transfer
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
    else $error("result without input transfer");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind fixed_frame_receiver_xor_check ffrx_checker u_ffrx_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: tb/frame_result_checker.sv
`timescale 1ns / 1ps

module frame_result_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // rx_byte
  input  logic                            s_tuser,   // stop_active
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // command, word_x, word_y, word_z, word_u
  input  logic [ffrx_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic [1:0]                      m_tuser,   // status
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ffrx_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ffrx_pkg::APB_DATA_W-1:0] pwdata,
  input  logic [ffrx_pkg::APB_DATA_W-1:0] prdata,
  input  logic                            pready,
  output int                              errors,
  output int                              pending
);
  import ffrx_pkg::*;

  localparam int FRAME_LEN = 20;

  typedef struct packed {
    status_t     status;
    frame_data_t data;
  } frame_outcome_t;

  frame_outcome_t    expected_frames[$];
  logic [POS_W-1:0]  byte_pos;
  logic [BYTE_W-1:0] frame_mem [FRAME_LEN];
  logic [BYTE_W-1:0] hdr_val;
  logic [BYTE_W-1:0] tail_val;
  int                fail_count = 0;
  int                queue_depth = 0;

  assign errors  = fail_count;
  assign pending = queue_depth;

  function automatic logic [WORD_W-1:0] le_word(input int first);
    return {frame_mem[first+3], frame_mem[first+2], frame_mem[first+1], frame_mem[first]};
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void take_byte(input logic [7:0] b, input logic stop);
    logic [BYTE_W-1:0] sum;
    frame_outcome_t    res;
    if (byte_pos >= FRAME_LEN) byte_pos = '0;
    frame_mem[byte_pos] = b;
    // an idle byte lands in slot 0 and is dropped unless it opens a frame
    if (byte_pos != 0 || b == hdr_val) byte_pos = byte_pos + 1'b1;
    else byte_pos = '0;
    if (byte_pos == FRAME_LEN) begin
      byte_pos = '0;
      sum = '0;
      for (int i = 0; i <= LAST_DATA_POS; i++) sum ^= frame_mem[i];
      // tail is checked ahead of the checksum
      if (frame_mem[TAIL_POS] != tail_val) res.status = ST_BAD_TAIL;
      else if (sum != frame_mem[CHECK_POS] || stop) res.status = ST_REJECT;
      else res.status = ST_OK;
      res.data.command = frame_mem[CMD_POS];
      res.data.word_x  = le_word(WORD_X_POS);
      res.data.word_y  = le_word(WORD_Y_POS);
      res.data.word_z  = le_word(WORD_Z_POS);
      res.data.word_u  = le_word(WORD_U_POS);
      expected_frames.push_back(res);
    end
  endfunction

  always @(posedge clk) begin
    frame_outcome_t want;
    frame_data_t    got;
    if (rst) begin
      byte_pos = '0;
      hdr_val  = HEADER_RESET;
      tail_val = TAIL_RESET;
      expected_frames.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_idx_t'(paddr[2]))
            REG_HEADER: hdr_val = pwdata[7:0];
            REG_TAIL:   tail_val = pwdata[7:0];
            default: ;
          endcase
        end else begin
          check_field("register read", (reg_idx_t'(paddr[2]) == REG_HEADER) ? hdr_val : tail_val,
                      prdata[7:0]);
        end
      end
      if (s_tvalid && s_tready) take_byte(s_tdata, s_tuser);
      if (m_tvalid && m_tready) begin
        if (expected_frames.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, actual status %0d",
                   $time, m_tuser);
          fail_count++;
        end else begin
          want = expected_frames.pop_front();
          got  = frame_data_t'(m_tdata);
          check_field("status", want.status, m_tuser);
          check_field("command", want.data.command, got.command);
          check_field("word_x", want.data.word_x, got.word_x);
          check_field("word_y", want.data.word_y, got.word_y);
          check_field("word_z", want.data.word_z, got.word_z);
          check_field("word_u", want.data.word_u, got.word_u);
        end
      end
    end
    queue_depth <= expected_frames.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ffrx_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int FRAME_LEN   = 20;
  localparam int PHASES      = 4;
  localparam int PHASE_FRAMES = 12;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_HEADER} fill_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    errors;
  int                    pending;

  logic [7:0] cur_hdr = HEADER_RESET;
  logic [7:0] cur_tail = TAIL_RESET;
  int         burst_left = 0;
  int         quiet_cycles = 0;
  int         stall_left = 0;
  int         stall_mode = 0;

  fixed_frame_receiver_xor_check i_dut (.*);

  frame_result_checker i_checker (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // receiver: switches between always ready, random stalls and a periodic stall
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= (stall_left % 8 < 3);
    endcase
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic stop);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= stop;
    do @(posedge clk); while (!s_tready);
    burst_left--;
  endtask

  task automatic send_noise(input int count);
    logic [7:0] b;
    repeat (count) begin
      do b = 8'($urandom_range(0, 255)); while (b == cur_hdr);
      send_byte(b, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic send_frame(input logic [7:0] cmd, input fill_t fill, input bit bad_sum,
                            input bit bad_tail, input bit stop);
    logic [7:0] fb [FRAME_LEN];
    logic [7:0] sum;
    fb[0] = cur_hdr;
    fb[1] = cmd;
    for (int i = 2; i <= LAST_DATA_POS; i++) begin
      case (fill)
        FILL_ZERO:   fb[i] = 8'h00;
        FILL_ONES:   fb[i] = 8'hFF;
        FILL_HEADER: fb[i] = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                                         : cur_hdr;
        default:     fb[i] = 8'($urandom_range(0, 255));
      endcase
    end
    sum = '0;
    for (int i = 0; i <= LAST_DATA_POS; i++) sum ^= fb[i];
    fb[CHECK_POS] = bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum;
    fb[TAIL_POS]  = bad_tail ? cur_tail ^ 8'($urandom_range(1, 255)) : cur_tail;
    for (int i = 0; i < FRAME_LEN; i++)
      send_byte(fb[i], (i == FRAME_LEN - 1) ? stop : 1'($urandom_range(0, 1)));
  endtask

  // waits until every result is out, then lets the output register settle
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [7:0] hdr, input logic [7:0] tail);
    drain();
    // upper data bits are random and must be ignored
    apb_access(1'b1, REG_HEADER, {24'($urandom), hdr});
    apb_access(1'b1, REG_TAIL, {24'($urandom), tail});
    apb_access(1'b0, REG_HEADER, '0);
    apb_access(1'b0, REG_TAIL, '0);
    cur_hdr  = hdr;
    cur_tail = tail;
  endtask

  initial begin : stimulus
    int kind;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_frame(8'h00, FILL_ZERO, 1'b0, 1'b0, 1'b0);
    send_frame(8'hFF, FILL_ONES, 1'b0, 1'b0, 1'b0);
    send_frame(8'h01, FILL_HEADER, 1'b0, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_frame(8'h00, FILL_RANDOM, 1'b0, 1'b0, 1'b1);
    send_frame(8'h01, FILL_RANDOM, 1'b1, 1'b0, 1'b0);
    send_frame(8'h00, FILL_RANDOM, 1'b0, 1'b1, 1'b0);
    send_frame(8'h01, FILL_RANDOM, 1'b1, 1'b1, 1'b1);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       set_regs(8'h00, 8'hFF);
        1:       set_regs(8'hFF, 8'h00);
        2:       set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        default: set_regs(HEADER_RESET, TAIL_RESET);
      endcase
      repeat (PHASE_FRAMES) begin
        if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 4));
        kind = $urandom_range(0, 99);
        send_frame(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 1)),
                   ($urandom_range(0, 9) == 0) ? FILL_HEADER : FILL_RANDOM,
                   (kind >= 70 && kind < 80) || kind >= 88,
                   kind >= 80,
                   $urandom_range(0, 9) == 0);
      end
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
